/* rtl/csi_pkg.sv */
package csi_pkg;

    localparam int CW    = 32;            // coordinate width
    localparam int RW    = CW - 1;        // radius width
    localparam int DW    = CW + 1;        // coordinate differences
    localparam int PW    = 2 * DW;        // signed products of differences
    localparam int AW    = 2 * CW + 1;    // |D|^2 and |F x D|
    localparam int BW    = AW + 1;        // F.D, signed
    localparam int R2W   = 2 * RW;        // r^2
    localparam int DSW   = AW + R2W;      // A*r^2 and the discriminant
    localparam int X2W   = 2 * AW;        // (F x D)^2
    localparam int SW    = (DSW + 1) / 2; // square root
    localparam int NW    = BW + 1;        // root numerators, signed
    localparam int MW    = CW;            // |dx|, |dy|
    localparam int UW    = AW + MW + 1;   // rounding dividend
    localparam int VW    = AW + 1;        // divisor 2A
    localparam int QW    = MW;            // quotient
    localparam int SPL   = DW;            // low part of a split operand
    localparam int LANES = 4;             // x and y offsets of both roots

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [DW-1:0] diff_t;

    typedef struct packed {
        coord_t x1;
        coord_t y1;
        diff_t  dx;
        diff_t  dy;
    } geo_t;

    typedef struct packed {
        logic                  miss;
        logic [AW-1:0]         a;
        logic signed [BW-1:0]  b;
        geo_t                  g;
    } sq_sb_t;

    typedef struct packed {
        logic   ok0;
        logic   ok1;
        coord_t x1;
        coord_t y1;
        logic   neg_x;
        logic   neg_y;
    } dv_sb_t;

    typedef logic [LANES-1:0][UW-1:0] num_vec_t;
    typedef logic [LANES-1:0][QW-1:0] quo_vec_t;

endpackage

/* rtl/csi_if.sv */
interface csi_req_if import csi_pkg::*; ();
    logic          valid;
    logic          ready;
    coord_t        seg_start_x;
    coord_t        seg_start_y;
    coord_t        seg_end_x;
    coord_t        seg_end_y;
    coord_t        center_x;
    coord_t        center_y;
    logic [RW-1:0] radius;

    modport source (output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                    center_x, center_y, radius, input ready);
    modport sink   (input valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                    center_x, center_y, radius, output ready);
endinterface

interface csi_res_if import csi_pkg::*; ();
    logic   valid;
    logic   ready;
    coord_t hit_x;
    coord_t hit_y;
    logic   root_index;
    logic   last_of_item;

    modport source (output valid, hit_x, hit_y, root_index, last_of_item, input ready);
    modport sink   (input valid, hit_x, hit_y, root_index, last_of_item, output ready);
endinterface

/* rtl/csi_sqrt.sv */
module csi_sqrt import csi_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  logic [DSW-1:0] rad,
    input  sq_sb_t         in_sb,
    output logic           out_valid,
    output logic [SW-1:0]  root,
    output sq_sb_t         out_sb
);

    localparam int TW = DSW + 1;

    logic [DSW-1:0] rem_w  [0:SW-1];
    logic [SW-1:0]  root_w [0:SW];
    sq_sb_t         sb_w   [0:SW];
    logic [SW:0]    vld_w;

    assign rem_w[0]  = rad;
    assign root_w[0] = '0;
    assign sb_w[0]   = in_sb;
    assign vld_w[0]  = in_valid;

    // one result bit per stage, most significant first
    for (genvar k = 0; k < SW; k++)
    begin : g_step
        localparam int BIT = SW - 1 - k;
        logic [TW-1:0] trial;
        logic          take;
        logic [SW-1:0] root_reg;
        logic [SW-1:0] root_next;
        sq_sb_t        sb_reg;
        logic          vld_reg;

        // (root + 2^BIT)^2 - root^2; the two terms share no bits
        always_comb
        begin
            trial     = ({{(TW - SW){1'b0}}, root_w[k]} << (BIT + 1))
                      | (TW'(1) << (2 * BIT));
            take      = {1'b0, rem_w[k]} >= trial;
            root_next = root_w[k] | (take ? (SW'(1) << BIT) : '0);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg <= 1'b0;
            end
            else if (en)
            begin
                vld_reg <= vld_w[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg <= root_next;
                sb_reg   <= sb_w[k];
            end
        end

        if (k < SW - 1)
        begin : g_rem
            logic [DSW-1:0] rem_reg;
            logic [DSW-1:0] rem_next;

            assign rem_next = take ? rem_w[k] - trial[DSW-1:0] : rem_w[k];

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg <= rem_next;
                end
            end

            assign rem_w[k+1] = rem_reg;
        end

        assign root_w[k+1] = root_reg;
        assign sb_w[k+1]   = sb_reg;
        assign vld_w[k+1]  = vld_reg;
    end

    assign out_valid = vld_w[SW];
    assign root      = root_w[SW];
    assign out_sb    = sb_w[SW];

endmodule

/* rtl/csi_div.sv */
module csi_div import csi_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [VW-1:0] dvsr,
    input  num_vec_t      num,
    input  dv_sb_t        in_sb,
    output logic          out_valid,
    output quo_vec_t      quo,
    output dv_sb_t        out_sb
);

    num_vec_t      rem_w  [0:QW-1];
    quo_vec_t      quo_w  [0:QW];
    logic [VW-1:0] dvsr_w [0:QW-1];
    dv_sb_t        sb_w   [0:QW];
    logic [QW:0]   vld_w;

    assign rem_w[0]  = num;
    assign quo_w[0]  = '0;
    assign dvsr_w[0] = dvsr;
    assign sb_w[0]   = in_sb;
    assign vld_w[0]  = in_valid;

    // restoring division, one quotient bit per stage for all lanes
    for (genvar k = 0; k < QW; k++)
    begin : g_step
        localparam int BIT = QW - 1 - k;
        logic [UW-1:0] trial;
        logic [LANES-1:0] take;
        quo_vec_t      quo_next;
        num_vec_t      rem_next;
        quo_vec_t      quo_reg;
        dv_sb_t        sb_reg;
        logic          vld_reg;

        assign trial = {{(UW - VW){1'b0}}, dvsr_w[k]} << BIT;

        always_comb
        begin
            for (int l = 0; l < LANES; l++)
            begin
                take[l]     = rem_w[k][l] >= trial;
                rem_next[l] = take[l] ? rem_w[k][l] - trial : rem_w[k][l];
                quo_next[l] = quo_w[k][l] | (take[l] ? (QW'(1) << BIT) : '0);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg <= 1'b0;
            end
            else if (en)
            begin
                vld_reg <= vld_w[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg <= quo_next;
                sb_reg  <= sb_w[k];
            end
        end

        if (k < QW - 1)
        begin : g_rem
            num_vec_t      rem_reg;
            logic [VW-1:0] dvsr_reg;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg  <= rem_next;
                    dvsr_reg <= dvsr_w[k];
                end
            end

            assign rem_w[k+1]  = rem_reg;
            assign dvsr_w[k+1] = dvsr_reg;
        end

        assign quo_w[k+1] = quo_reg;
        assign sb_w[k+1]  = sb_reg;
        assign vld_w[k+1] = vld_reg;
    end

    assign out_valid = vld_w[QW];
    assign quo       = quo_w[QW];
    assign out_sb    = sb_w[QW];

endmodule

/* rtl/circle_segment_intersect_core.sv */
// Segment / circle intersection in Q16.16. A request carries a segment, a circle centre and a
// radius; the block returns zero, one or two points, the smaller root first, the last one marked
// with last_of_item (a tangent gives the same point twice, a zero-length segment or a miss gives
// nothing). The datapath is a fully pipelined chain of 106 register stages: six for the exact
// products and the discriminant, 64 for the square root (one bit per stage), three for the root
// numerators and the rounding products, 32 for the four parallel divisions and one output
// register. A new request can enter every cycle; the single result channel limits the sustained
// rate to one request per cycle when each gives at most one point, and when each gives two the
// chain holds while the first of them is shown. A stall on the result side holds the whole
// chain; empty slots at its tail still drain.
module circle_segment_intersect_core import csi_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    csi_req_if.sink   req,
    csi_res_if.source rsp
);

    localparam int HI = AW - SPL;

    logic adv;
    logic [5:0] vld_reg;   // front stages 1..6
    logic [2:0] vld2_reg;  // stages after the square root

    // ---------------------------------------------------------------- stage 1
    geo_t          s1_g_reg;
    diff_t         s1_fx_reg;
    diff_t         s1_fy_reg;
    logic [RW-1:0] s1_r_reg;
    geo_t          s1_g_next;

    always_comb
    begin
        s1_g_next.x1 = req.seg_start_x;
        s1_g_next.y1 = req.seg_start_y;
        s1_g_next.dx = diff_t'(req.seg_end_x) - diff_t'(req.seg_start_x);
        s1_g_next.dy = diff_t'(req.seg_end_y) - diff_t'(req.seg_start_y);
    end

    // ---------------------------------------------------------------- stage 2
    geo_t                 s2_g_reg;
    logic signed [PW-1:0] s2_dxx_reg, s2_dyy_reg, s2_fxdx_reg, s2_fydy_reg;
    logic signed [PW-1:0] s2_fxdy_reg, s2_fydx_reg;
    logic [R2W-1:0]       s2_rsq_reg;

    // ---------------------------------------------------------------- stage 3
    geo_t                 s3_g_reg;
    logic [AW-1:0]        s3_a_reg;
    logic                 s3_azero_reg;
    logic signed [BW-1:0] s3_b_reg;
    logic [AW-1:0]        s3_xm_reg;
    logic [R2W-1:0]       s3_rsq_reg;
    logic signed [PW-1:0] s3_a_next, s3_x_next, s3_xneg_next;

    always_comb
    begin
        s3_a_next    = s2_dxx_reg + s2_dyy_reg;
        s3_x_next    = s2_fxdy_reg - s2_fydx_reg;
        s3_xneg_next = -s3_x_next;
    end

    // ---------------------------------------------------------------- stage 4
    geo_t                    s4_g_reg;
    logic [AW-1:0]           s4_a_reg;
    logic                    s4_azero_reg;
    logic signed [BW-1:0]    s4_b_reg;
    logic [SPL+RW-1:0]       s4_pll_reg, s4_plh_reg;
    logic [HI+RW-1:0]        s4_phl_reg, s4_phh_reg;
    logic [2*SPL-1:0]        s4_qll_reg;
    logic [SPL+HI-1:0]       s4_qlh_reg;
    logic [2*HI-1:0]         s4_qhh_reg;

    // ---------------------------------------------------------------- stage 5
    geo_t                 s5_g_reg;
    logic [AW-1:0]        s5_a_reg;
    logic                 s5_azero_reg;
    logic signed [BW-1:0] s5_b_reg;
    logic [DSW-1:0]       s5_ar2_reg;
    logic [X2W-1:0]       s5_x2_reg;

    // ---------------------------------------------------------------- stage 6
    sq_sb_t         s6_sb_reg;
    logic [DSW-1:0] s6_disc_reg;
    sq_sb_t         s6_sb_next;

    always_comb
    begin
        s6_sb_next.miss = s5_azero_reg || (s5_x2_reg > X2W'(s5_ar2_reg));
        s6_sb_next.a    = s5_a_reg;
        s6_sb_next.b    = s5_b_reg;
        s6_sb_next.g    = s5_g_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[4:0], req.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_g_reg     <= s1_g_next;
            s1_fx_reg    <= diff_t'(req.seg_start_x) - diff_t'(req.center_x);
            s1_fy_reg    <= diff_t'(req.seg_start_y) - diff_t'(req.center_y);
            s1_r_reg     <= req.radius;

            s2_g_reg     <= s1_g_reg;
            s2_dxx_reg   <= s1_g_reg.dx * s1_g_reg.dx;
            s2_dyy_reg   <= s1_g_reg.dy * s1_g_reg.dy;
            s2_fxdx_reg  <= s1_fx_reg * s1_g_reg.dx;
            s2_fydy_reg  <= s1_fy_reg * s1_g_reg.dy;
            s2_fxdy_reg  <= s1_fx_reg * s1_g_reg.dy;
            s2_fydx_reg  <= s1_fy_reg * s1_g_reg.dx;
            s2_rsq_reg   <= s1_r_reg * s1_r_reg;

            s3_g_reg     <= s2_g_reg;
            s3_a_reg     <= s3_a_next[AW-1:0];
            s3_azero_reg <= (s3_a_next == '0);
            s3_b_reg     <= s2_fxdx_reg + s2_fydy_reg;
            s3_xm_reg    <= s3_x_next[PW-1] ? s3_xneg_next[AW-1:0] : s3_x_next[AW-1:0];
            s3_rsq_reg   <= s2_rsq_reg;

            // A*r^2 and X^2 as partial products
            s4_g_reg     <= s3_g_reg;
            s4_a_reg     <= s3_a_reg;
            s4_azero_reg <= s3_azero_reg;
            s4_b_reg     <= s3_b_reg;
            s4_pll_reg   <= s3_a_reg[SPL-1:0] * s3_rsq_reg[RW-1:0];
            s4_plh_reg   <= s3_a_reg[SPL-1:0] * s3_rsq_reg[R2W-1:RW];
            s4_phl_reg   <= s3_a_reg[AW-1:SPL] * s3_rsq_reg[RW-1:0];
            s4_phh_reg   <= s3_a_reg[AW-1:SPL] * s3_rsq_reg[R2W-1:RW];
            s4_qll_reg   <= s3_xm_reg[SPL-1:0] * s3_xm_reg[SPL-1:0];
            s4_qlh_reg   <= s3_xm_reg[SPL-1:0] * s3_xm_reg[AW-1:SPL];
            s4_qhh_reg   <= s3_xm_reg[AW-1:SPL] * s3_xm_reg[AW-1:SPL];

            s5_g_reg     <= s4_g_reg;
            s5_a_reg     <= s4_a_reg;
            s5_azero_reg <= s4_azero_reg;
            s5_b_reg     <= s4_b_reg;
            s5_ar2_reg   <= DSW'(s4_pll_reg) + (DSW'(s4_plh_reg) << RW)
                          + (DSW'(s4_phl_reg) << SPL) + (DSW'(s4_phh_reg) << (SPL + RW));
            s5_x2_reg    <= X2W'(s4_qll_reg) + (X2W'(s4_qlh_reg) << (SPL + 1))
                          + (X2W'(s4_qhh_reg) << (2 * SPL));

            // quarter discriminant A*r^2 - X^2, only meaningful without a miss
            s6_sb_reg    <= s6_sb_next;
            s6_disc_reg  <= s5_ar2_reg - s5_x2_reg[DSW-1:0];
        end
    end

    // ---------------------------------------------------------------- square root
    logic          sq_vld;
    logic [SW-1:0] sq_root;
    sq_sb_t        sq_sb;

    csi_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (vld_reg[5]),
        .rad       (s6_disc_reg),
        .in_sb     (s6_sb_reg),
        .out_valid (sq_vld),
        .root      (sq_root),
        .out_sb    (sq_sb)
    );

    // ---------------------------------------------------------------- stage 7
    logic signed [NW-1:0] s7_bx, s7_sx, s7_n0, s7_n1;
    logic [NW-1:0]        s7_aw;
    diff_t                s7_ndx, s7_ndy;
    logic                 s7_ok0_reg, s7_ok1_reg;
    logic [AW-1:0]        s7_n0_reg, s7_n1_reg, s7_a_reg;
    coord_t               s7_x1_reg, s7_y1_reg;
    logic [MW-1:0]        s7_mx_reg, s7_my_reg;
    logic                 s7_negx_reg, s7_negy_reg;

    always_comb
    begin
        s7_bx  = {{(NW - BW){sq_sb.b[BW-1]}}, sq_sb.b};
        s7_sx  = $signed({{(NW - SW){1'b0}}, sq_root});
        s7_n0  = -s7_bx - s7_sx;
        s7_n1  = -s7_bx + s7_sx;
        s7_aw  = {{(NW - AW){1'b0}}, sq_sb.a};
        s7_ndx = -sq_sb.g.dx;
        s7_ndy = -sq_sb.g.dy;
    end

    // ---------------------------------------------------------------- stage 8
    logic [LANES-1:0][SPL+MW-1:0] s8_lo_reg;
    logic [LANES-1:0][HI+MW-1:0]  s8_hi_reg;
    logic [AW-1:0]                s8_a_reg;
    dv_sb_t                       s8_sb_reg;
    logic [LANES-1:0][AW-1:0]     s8_n;
    logic [LANES-1:0][MW-1:0]     s8_m;

    always_comb
    begin
        s8_n[0] = s7_n0_reg;
        s8_n[1] = s7_n0_reg;
        s8_n[2] = s7_n1_reg;
        s8_n[3] = s7_n1_reg;
        s8_m[0] = s7_mx_reg;
        s8_m[1] = s7_my_reg;
        s8_m[2] = s7_mx_reg;
        s8_m[3] = s7_my_reg;
    end

    // ---------------------------------------------------------------- stage 9
    num_vec_t      s9_num_reg;
    logic [VW-1:0] s9_dv_reg;
    dv_sb_t        s9_sb_reg;
    num_vec_t      s9_num_next;
    logic [LANES-1:0][AW+MW-1:0] s9_prod;

    // 2*N*|d| + A over 2A rounds the offset to nearest
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            s9_prod[l]     = {s8_hi_reg[l], {SPL{1'b0}}} + {{HI{1'b0}}, s8_lo_reg[l]};
            s9_num_next[l] = {s9_prod[l], 1'b0} + {{(UW - AW){1'b0}}, s8_a_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld2_reg <= '0;
        end
        else if (adv)
        begin
            vld2_reg <= {vld2_reg[1:0], sq_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s7_ok0_reg  <= !sq_sb.miss && !s7_n0[NW-1] && ($unsigned(s7_n0) <= s7_aw);
            s7_ok1_reg  <= !sq_sb.miss && !s7_n1[NW-1] && ($unsigned(s7_n1) <= s7_aw);
            s7_n0_reg   <= s7_n0[AW-1:0];
            s7_n1_reg   <= s7_n1[AW-1:0];
            s7_a_reg    <= sq_sb.a;
            s7_x1_reg   <= sq_sb.g.x1;
            s7_y1_reg   <= sq_sb.g.y1;
            s7_mx_reg   <= sq_sb.g.dx[DW-1] ? s7_ndx[MW-1:0] : sq_sb.g.dx[MW-1:0];
            s7_my_reg   <= sq_sb.g.dy[DW-1] ? s7_ndy[MW-1:0] : sq_sb.g.dy[MW-1:0];
            s7_negx_reg <= sq_sb.g.dx[DW-1];
            s7_negy_reg <= sq_sb.g.dy[DW-1];

            for (int l = 0; l < LANES; l++)
            begin
                s8_lo_reg[l] <= s8_n[l][SPL-1:0] * s8_m[l];
                s8_hi_reg[l] <= s8_n[l][AW-1:SPL] * s8_m[l];
            end
            s8_a_reg        <= s7_a_reg;
            s8_sb_reg.ok0   <= s7_ok0_reg;
            s8_sb_reg.ok1   <= s7_ok1_reg;
            s8_sb_reg.x1    <= s7_x1_reg;
            s8_sb_reg.y1    <= s7_y1_reg;
            s8_sb_reg.neg_x <= s7_negx_reg;
            s8_sb_reg.neg_y <= s7_negy_reg;

            s9_num_reg <= s9_num_next;
            s9_dv_reg  <= {s8_a_reg, 1'b0};
            s9_sb_reg  <= s8_sb_reg;
        end
    end

    // ---------------------------------------------------------------- division
    logic     dv_vld;
    quo_vec_t dv_quo;
    dv_sb_t   dv_sb;

    csi_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (vld2_reg[2]),
        .dvsr      (s9_dv_reg),
        .num       (s9_num_reg),
        .in_sb     (s9_sb_reg),
        .out_valid (dv_vld),
        .quo       (dv_quo),
        .out_sb    (dv_sb)
    );

    // ---------------------------------------------------------------- output register
    function automatic coord_t place(coord_t p, logic neg, logic [QW-1:0] q);
        logic [CW+1:0] pe;
        logic [CW+1:0] qe;
        logic [CW+1:0] s;
        logic          ovf;
        pe  = {{2{p[CW-1]}}, p};
        qe  = {2'b00, q};
        s   = neg ? pe - qe : pe + qe;
        ovf = (s[CW+1:CW-1] != '0) && (s[CW+1:CW-1] != '1);
        return ovf ? {s[CW+1], {(CW-1){!s[CW+1]}}} : s[CW-1:0];
    endfunction

    logic   pend0_reg, pend1_reg;
    coord_t hx0_reg, hy0_reg, hx1_reg, hy1_reg;
    logic   busy;
    logic   leave_last;

    assign busy       = pend0_reg || pend1_reg;
    assign leave_last = rsp.valid && rsp.ready && rsp.last_of_item;
    assign adv        = !busy || leave_last || !dv_vld;

    assign req.ready        = adv;
    assign rsp.valid        = busy;
    assign rsp.root_index   = !pend0_reg;
    assign rsp.last_of_item = !(pend0_reg && pend1_reg);
    assign rsp.hit_x        = pend0_reg ? hx0_reg : hx1_reg;
    assign rsp.hit_y        = pend0_reg ? hy0_reg : hy1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend0_reg <= 1'b0;
            pend1_reg <= 1'b0;
        end
        else if (adv && dv_vld)
        begin
            pend0_reg <= dv_sb.ok0;
            pend1_reg <= dv_sb.ok1;
        end
        else if (rsp.valid && rsp.ready)
        begin
            if (pend0_reg)
            begin
                pend0_reg <= 1'b0;
            end
            else
            begin
                pend1_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && dv_vld)
        begin
            hx0_reg <= place(dv_sb.x1, dv_sb.neg_x, dv_quo[0]);
            hy0_reg <= place(dv_sb.y1, dv_sb.neg_y, dv_quo[1]);
            hx1_reg <= place(dv_sb.x1, dv_sb.neg_x, dv_quo[2]);
            hy1_reg <= place(dv_sb.y1, dv_sb.neg_y, dv_quo[3]);
        end
    end

    // ---------------------------------------------------------------- checks
    a_hold_blocks_intake: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !leave_last && dv_vld) |-> !req.ready)
        else $error("request taken while finished points still wait");

    a_second_root_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.ready && !rsp.last_of_item) |=> (rsp.valid && rsp.root_index))
        else $error("larger root did not follow the smaller one");

    a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (leave_last && !dv_vld) |=> !rsp.valid)
        else $error("point shown with nothing behind it");

endmodule

/* dv/circle_segment_intersect_core_tb.sv */
module circle_segment_intersect_core_tb;
    import csi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [255:0] wide_t;

    typedef struct {
        coord_t x;
        coord_t y;
        logic   root;
        logic   last;
    } hit_t;

    class hit_scoreboard;
        hit_t pending_hits[$];
        int   errors;
        int   hits_seen;
        int   requests_seen;

        function wide_t isqrt(wide_t v);
            wide_t res;
            wide_t bit_w;
            res   = 0;
            bit_w = wide_t'(1) <<< 252;
            while (bit_w > v)
                bit_w = bit_w >>> 2;
            while (bit_w != 0)
            begin
                if (v >= res + bit_w)
                begin
                    v   = v - (res + bit_w);
                    res = (res >>> 1) + bit_w;
                end
                else
                    res = res >>> 1;
                bit_w = bit_w >>> 2;
            end
            return res;
        endfunction

        // offset rounded to nearest, ties away from the start point
        function coord_t place(coord_t p0, wide_t dc, wide_t n, wide_t a);
            wide_t mag;
            wide_t q;
            wide_t r;
            mag = (dc < 0) ? -dc : dc;
            q   = (2 * n * mag + a) / (2 * a);
            if (q > mag)
                q = mag;
            r = (dc < 0) ? wide_t'(p0) - q : wide_t'(p0) + q;
            if (r > 64'sd2147483647)
                r = 64'sd2147483647;
            if (r < -64'sd2147483648)
                r = -64'sd2147483648;
            return r[CW-1:0];
        endfunction

        function void note_request(coord_t sx, coord_t sy, coord_t ex, coord_t ey,
                                   coord_t cx, coord_t cy, logic [RW-1:0] rad);
            wide_t dx, dy, fx, fy, a, b, xc, disc, s, n, rr;
            hit_t  h;
            int    first;
            requests_seen++;
            dx = wide_t'(ex) - wide_t'(sx);
            dy = wide_t'(ey) - wide_t'(sy);
            fx = wide_t'(sx) - wide_t'(cx);
            fy = wide_t'(sy) - wide_t'(cy);
            rr = wide_t'({1'b0, rad});
            a  = dx * dx + dy * dy;
            if (a == 0)
                return;
            b    = fx * dx + fy * dy;
            xc   = fx * dy - fy * dx;
            disc = a * rr * rr - xc * xc;
            if (disc < 0)
                return;
            s     = isqrt(disc);
            first = pending_hits.size();
            for (int k = 0; k < 2; k++)
            begin
                n = k ? -b + s : -b - s;
                if (n < 0 || n > a)
                    continue;
                h.x    = place(sx, dx, n, a);
                h.y    = place(sy, dy, n, a);
                h.root = k[0];
                h.last = 1'b0;
                pending_hits = {pending_hits, h};
            end
            if (pending_hits.size() > first)
                pending_hits[pending_hits.size() - 1].last = 1'b1;
        endfunction

        function void check_result(coord_t hx, coord_t hy, logic root, logic last);
            hit_t e;
            hits_seen++;
            if (pending_hits.size() == 0)
            begin
                $display("%0t: unexpected hit x=%h y=%h root=%b last=%b",
                         $realtime, hx, hy, root, last);
                errors++;
                return;
            end
            e = pending_hits.pop_front();
            if (e.x !== hx)
            begin
                $display("%0t: hit_x expected %h actual %h", $realtime, e.x, hx);
                errors++;
            end
            if (e.y !== hy)
            begin
                $display("%0t: hit_y expected %h actual %h", $realtime, e.y, hy);
                errors++;
            end
            if (e.root !== root)
            begin
                $display("%0t: root_index expected %b actual %b", $realtime, e.root, root);
                errors++;
            end
            if (e.last !== last)
            begin
                $display("%0t: last_of_item expected %b actual %b",
                         $realtime, e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    csi_req_if req_ch ();
    csi_res_if rsp_ch ();

    circle_segment_intersect_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    hit_scoreboard sb;
    int            idle_mode;    // 0: sender 16%, receiver 80%; 1: swapped; 2: none
    int            hold_cycles;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    initial
    begin
        #5ms;
        $display("circle_segment_intersect_core: mismatch");
        $finish;
    end

    // result side
    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                rsp_ch.ready <= 1'b0;
            end
            else if (idle_mode == 0)
                rsp_ch.ready <= ($urandom_range(99) >= 80);
            else if (idle_mode == 1)
                rsp_ch.ready <= ($urandom_range(99) >= 16);
            else
                rsp_ch.ready <= 1'b1;
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_result(rsp_ch.hit_x, rsp_ch.hit_y,
                                rsp_ch.root_index, rsp_ch.last_of_item);
        end
    end

    task automatic send_request(coord_t sx, coord_t sy, coord_t ex, coord_t ey,
                                coord_t cx, coord_t cy, logic [RW-1:0] rad);
        int pct;
        pct = (idle_mode == 0) ? 16 : (idle_mode == 1) ? 80 : 0;
        if ($urandom_range(99) < pct)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.seg_start_x <= sx;
        req_ch.seg_start_y <= sy;
        req_ch.seg_end_x   <= ex;
        req_ch.seg_end_y   <= ey;
        req_ch.center_x    <= cx;
        req_ch.center_y    <= cy;
        req_ch.radius      <= rad;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_request(sx, sy, ex, ey, cx, cy, rad);
    endtask

    function automatic coord_t near(coord_t c, int span);
        return coord_t'(c + $signed($urandom_range(2 * span)) - span);
    endfunction

    task automatic random_request();
        coord_t cx, cy, sx, sy, ex, ey;
        int     span, rad, kind;
        kind = $urandom_range(99);
        if (kind < 15)
            send_request($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         RW'($urandom));
        else
        begin
            cx   = $signed($urandom) >>> 3;
            cy   = $signed($urandom) >>> 3;
            rad  = $urandom_range(1 << $urandom_range(24));
            span = 2 * rad + 16;
            if (kind < 22)
            begin
                // tangent along a horizontal line
                sx = cx - span;
                ex = cx + span;
                sy = cy + rad;
                send_request(sx, sy, ex, sy, cx, cy, RW'(rad));
            end
            else if (kind < 27)
            begin
                sx = near(cx, span);
                sy = near(cy, span);
                send_request(sx, sy, sx, sy, cx, cy, RW'(rad));
            end
            else
                send_request(near(cx, span), near(cy, span), near(cx, span),
                             near(cy, span), cx, cy, RW'(rad));
        end
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending_hits.size() != 0);
    endtask

    initial
    begin
        coord_t mx, mn;
        sb          = new();
        idle_mode   = 2;
        hold_cycles = 0;
        mx          = 32'h7fff_ffff;
        mn          = 32'h8000_0000;
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.seg_start_x = '0;
        req_ch.seg_start_y = '0;
        req_ch.seg_end_x   = '0;
        req_ch.seg_end_y   = '0;
        req_ch.center_x    = '0;
        req_ch.center_y    = '0;
        req_ch.radius      = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: two roots, start inside, tangent, miss, degenerate, extremes
        send_request(-32'sh30000, 0, 32'sh30000, 0, 0, 0, 31'h10000);
        send_request(0, 0, 32'sh30000, 0, 0, 0, 31'h10000);
        send_request(-32'sh30000, 32'sh10000, 32'sh30000, 32'sh10000, 0, 0, 31'h10000);
        send_request(-32'sh30000, 32'sh20000, 32'sh30000, 32'sh20000, 0, 0, 31'h10000);
        send_request(32'sh5000, 32'sh5000, 32'sh5000, 32'sh5000, 0, 0, 31'h10000);
        send_request(0, 0, 100, 0, 0, 0, 0);
        send_request(0, 0, 0, 0, 0, 0, 0);
        send_request(mn, mn, mx, mx, 0, 0, 31'h7fff_ffff);
        send_request(mx, mx, mn, mn, mx, mn, 31'h7fff_ffff);
        send_request(mn, mx, mx, mn, mn, mn, 31'h7fff_ffff);
        send_request(mn, 0, mx, 0, 0, 0, 31'h7fff_ffff);
        send_request(mx, mx, mn, mn, mn, mn, 0);
        send_request(mn, mn, mx, mn, 0, mn, 31'h1);
        send_request(-32'sh10000, 0, 32'sh10000, 0, 32'sh10000, 0, 31'h10000);
        send_request(32'sh10000, 0, -32'sh10000, 0, 0, 0, 31'h10000);
        send_request(0, -32'sh40000, 0, 32'sh40000, 32'sh8000, 0, 31'h10000);
        send_request(3, 7, -11, 5, 1, 2, 31'd9);
        send_request(mx, mx, mx, mx, mn, mn, 31'h7fff_ffff);

        for (int phase = 0; phase < 3; phase++)
        begin
            idle_mode = phase;
            for (int i = 0; i < 240; i++)
            begin
                if (i == 60)
                    hold_cycles = 400;
                if (i == 150)
                    wait_drained();
                random_request();
            end
        end
        wait_drained();
        repeat (150) @(posedge clk);
        $display("%0d requests sent, %0d hits checked, over idle mixes, a long",
                 sb.requests_seen, sb.hits_seen);
        $display("result stall, tangents, misses, degenerate and extreme segments");
        if (sb.errors == 0 && sb.pending_hits.size() == 0)
            $display("circle_segment_intersect_core: match");
        else
            $display("circle_segment_intersect_core: mismatch");
        $finish;
    end

endmodule
